/* hw/rtl/pqc_pkg.sv */
// Shared types, codes and defaults for the playlist queue.
`default_nettype none

package pqc_pkg;

  // Default geometry.
  localparam int PQC_DEPTH   = 16;
  localparam int PQC_ID_BITS = 16;

  // Field widths fixed by the command and response formats.
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // Command codes; codes five to seven behave as a query.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_NEXT   = 3'd2,
    ACT_PLAY   = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_READ,
    ST_DONE
  } state_t;

  // Broadcast control for the row of storage cells.
  typedef struct packed {
    logic wr;     // write the appended identifier into the cell at the write index
    logic shift;  // cells below the tail take their upper neighbour's entry
    logic wrap;   // the tail cell takes the head entry during a shift
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/pqc_if.sv */
// Command and response channel interfaces of the playlist queue.
`default_nettype none

interface pqc_cmd_if #(
  parameter int ID_BITS = pqc_pkg::PQC_ID_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic [pqc_pkg::ACTION_W-1:0]  action;
  logic [ID_BITS-1:0]            song_id;

  modport source (output valid, action, song_id, input ready);
  modport sink   (input valid, action, song_id, output ready);
endinterface

interface pqc_rsp_if #(
  parameter int ID_BITS  = pqc_pkg::PQC_ID_BITS,
  parameter int CNT_BITS = $clog2(pqc_pkg::PQC_DEPTH + 1)
) ();
  logic                          valid;
  logic                          ready;
  logic [ID_BITS-1:0]            current_id;
  logic [CNT_BITS-1:0]           entry_count;
  logic [pqc_pkg::STATUS_W-1:0]  status;

  modport source (output valid, current_id, entry_count, status, input ready);
  modport sink   (input valid, current_id, entry_count, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/playlist_queue_with_cursor.sv */
// Top level of the playlist queue: sequencer, counters and the row of storage cells.
`default_nettype none

// The queue holds up to DEPTH identifiers in a row of cells and a cursor on
// the current entry. Items are taken one at a time. For add, play-now, next
// and query the response is registered after the current identifier has
// travelled down a registered read chain through every cell, one cell per
// cycle. A remove with the list non-empty first walks the held entries one
// per cycle. It rotates the row so that kept entries go round once and
// deleted ones drop out; the read chain then runs as for the other commands.
// The next command is accepted in the cycle after the response is registered,
// even while that response still waits to be taken. A finished item waits
// in the done state for as long as an earlier response is still held.
module playlist_queue_with_cursor #(
  parameter int DEPTH   = pqc_pkg::PQC_DEPTH,
  parameter int ID_BITS = pqc_pkg::PQC_ID_BITS
) (
  input logic        clk,
  input logic        rst,
  pqc_cmd_if.sink    cmd,
  pqc_rsp_if.source  rsp
);
  import pqc_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer and bookkeeping registers.
  state_t             state, state_next;
  logic [CNT_W-1:0]   occ, occ_next;
  logic [IDX_W-1:0]   cursor, cursor_next;
  logic [IDX_W-1:0]   step, step_next;
  logic [CNT_W-1:0]   live, live_next;
  logic [CNT_W-1:0]   kept, kept_next;
  logic               pending, pending_next;
  logic [IDX_W-1:0]   new_cur, new_cur_next;
  status_t            result_status, result_status_next;
  logic [ID_BITS-1:0] op_id;

  // Response register.
  logic               rsp_valid;
  logic [ID_BITS-1:0] rsp_id;
  logic [CNT_W-1:0]   rsp_count;
  status_t            rsp_status;

  // Cell row.
  cell_ctrl_t         ctrl;
  logic [IDX_W-1:0]   tail_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [ID_BITS-1:0] entry   [DEPTH];
  logic [ID_BITS-1:0] rd      [DEPTH];
  logic [ID_BITS-1:0] nb_entry[DEPTH];
  logic [ID_BITS-1:0] nb_rd   [DEPTH];

  logic               cmd_fire;
  logic               keep;
  logic               remove_last;
  logic               read_last;
  logic               rsp_load;

  assign cmd_fire    = cmd.valid && cmd.ready;
  assign keep        = (entry[0] != op_id);
  assign remove_last = ((CNT_W'(step) + CNT_W'(1)) == occ);
  assign read_last   = (step == IDX_W'(DEPTH - 1));
  assign rsp_load    = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          if ((action_t'(cmd.action) == ACT_REMOVE) && (occ != '0)) begin
            state_next = ST_REMOVE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_REMOVE: begin
        if (remove_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (read_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control and register updates per state.
  always_comb begin
    occ_next           = occ;
    cursor_next        = cursor;
    step_next          = step;
    live_next          = live;
    kept_next          = kept;
    pending_next       = pending;
    new_cur_next       = new_cur;
    result_status_next = result_status;
    ctrl               = '0;
    wr_idx             = occ[IDX_W-1:0];
    tail_idx           = IDX_W'(live - CNT_W'(1));
    cmd.ready          = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          result_status_next = STATUS_OK;
          step_next          = '0;
          unique case (action_t'(cmd.action))
            ACT_ADD, ACT_PLAY: begin
              if (occ == CNT_W'(DEPTH)) begin
                result_status_next = STATUS_FULL;
              end else begin
                ctrl.wr  = 1'b1;
                occ_next = occ + CNT_W'(1);
                // Play-now puts the cursor on the new last entry; add to an
                // empty list leaves it at zero, which is the new entry.
                if (action_t'(cmd.action) == ACT_PLAY) begin
                  cursor_next = occ[IDX_W-1:0];
                end
              end
            end
            ACT_NEXT: begin
              if (occ == '0) begin
                result_status_next = STATUS_EMPTY;
              end else if ((CNT_W'(cursor) + CNT_W'(1)) == occ) begin
                cursor_next = '0;
              end else begin
                cursor_next = cursor + IDX_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (occ == '0) begin
                result_status_next = STATUS_EMPTY;
              end else begin
                live_next    = occ;
                kept_next    = '0;
                pending_next = 1'b0;
                new_cur_next = '0;
              end
            end
            default: begin
              if (occ == '0) begin
                result_status_next = STATUS_EMPTY;
              end
            end
          endcase
        end
      end

      ST_REMOVE: begin
        // The head cell holds original entry number step. A kept entry goes
        // round to the tail; a deleted one drops out and the ring shortens.
        ctrl.shift = 1'b1;
        ctrl.wrap  = keep;
        live_next  = keep ? live : (live - CNT_W'(1));
        kept_next  = kept + CNT_W'(keep);
        step_next  = step + IDX_W'(1);
        if (step == cursor) begin
          if (keep) begin
            new_cur_next = kept[IDX_W-1:0];
          end else begin
            pending_next = 1'b1;
          end
        end else if (pending && keep) begin
          new_cur_next = kept[IDX_W-1:0];
          pending_next = 1'b0;
        end
        if (remove_last) begin
          step_next = '0;
          occ_next  = kept_next;
          // A deleted current entry with no survivor after it wraps to the
          // first entry, as does a list that became empty.
          cursor_next = (pending_next || (kept_next == '0)) ? '0 : new_cur_next;
        end
      end

      ST_READ: begin
        step_next = step + IDX_W'(1);
      end

      ST_DONE: begin
        step_next = '0;
      end

      default: begin
        step_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      occ     <= '0;
      cursor  <= '0;
      step    <= '0;
      live    <= '0;
      kept    <= '0;
      pending <= 1'b0;
      new_cur <= '0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      cursor  <= cursor_next;
      step    <= step_next;
      live    <= live_next;
      kept    <= kept_next;
      pending <= pending_next;
      new_cur <= new_cur_next;
    end
  end

  // Command payload and status held for the item in progress.
  always_ff @(posedge clk) begin
    result_status <= result_status_next;
    if (cmd_fire) begin
      op_id <= cmd.song_id;
    end
  end

  // Response register: the next item may start while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_id     <= (occ == '0) ? '0 : rd[0];
      rsp_count  <= occ;
      rsp_status <= result_status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.current_id  = rsp_id;
  assign rsp.entry_count = rsp_count;
  assign rsp.status      = rsp_status;

  // The row of cells, each linked to its upper neighbour.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign nb_entry[i] = entry[i];
      assign nb_rd[i]    = '0;
    end else begin : g_link
      assign nb_entry[i] = entry[i+1];
      assign nb_rd[i]    = rd[i+1];
    end

    pqc_cell #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS),
      .INDEX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .tail_idx   (tail_idx),
      .wr_idx     (wr_idx),
      .rd_idx     (cursor),
      .wr_data    (cmd.song_id),
      .head       (entry[0]),
      .next_entry (nb_entry[i]),
      .next_rd    (nb_rd[i]),
      .entry      (entry[i]),
      .rd         (rd[i])
    );
  end

  // The cursor stays on a held entry, and at zero while the list is empty.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (occ != '0) |-> (CNT_W'(cursor) < occ))
    else $error("cursor beyond the held entries");

  a_cursor_empty: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (cursor == '0))
    else $error("cursor not at zero on an empty list");

  // The rotating ring never runs out while a remove is still walking it.
  a_live_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REMOVE) |-> (live != '0))
    else $error("remove ring emptied before the walk ended");

  // A remove never makes the list longer.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REMOVE) && remove_last |=> (occ <= $past(occ)))
    else $error("remove grew the entry count");

  // A response only appears after the read chain has been run.
  a_rsp_after_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DONE))
    else $error("response raised outside the done state");

endmodule

`default_nettype wire

/* hw/rtl/pqc_cell.sv */
// One storage cell of the playlist row: an entry register and a read-chain stage.
`default_nettype none

module pqc_cell #(
  parameter int DEPTH   = pqc_pkg::PQC_DEPTH,
  parameter int ID_BITS = pqc_pkg::PQC_ID_BITS,
  parameter int INDEX   = 0
) (
  input  logic                       clk,
  input  pqc_pkg::cell_ctrl_t        ctrl,
  input  logic [$clog2(DEPTH)-1:0]   tail_idx,
  input  logic [$clog2(DEPTH)-1:0]   wr_idx,
  input  logic [$clog2(DEPTH)-1:0]   rd_idx,
  input  logic [ID_BITS-1:0]         wr_data,
  input  logic [ID_BITS-1:0]         head,
  input  logic [ID_BITS-1:0]         next_entry,
  input  logic [ID_BITS-1:0]         next_rd,
  output logic [ID_BITS-1:0]         entry,
  output logic [ID_BITS-1:0]         rd
);
  import pqc_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  // Entry update: an append write wins, otherwise the row shifts towards
  // cell zero and the tail cell may take the head entry round again.
  always_ff @(posedge clk) begin
    priority if (ctrl.wr && (wr_idx == MY_IDX)) begin
      entry <= wr_data;
    end else if (ctrl.shift && (MY_IDX < tail_idx)) begin
      entry <= next_entry;
    end else if (ctrl.shift && ctrl.wrap && (MY_IDX == tail_idx)) begin
      entry <= head;
    end else begin
      entry <= entry;
    end
  end

  // Read chain: the selected cell injects its entry, the others pass the
  // value along one cell per cycle towards cell zero.
  always_ff @(posedge clk) begin
    rd <= (rd_idx == MY_IDX) ? entry : next_rd;
  end

endmodule

`default_nettype wire
